// File: rtl/lfpd_pkg.sv
// shared types, constants and register codes for the line follower drive core
`timescale 1ns / 1ps
`default_nettype none
package lfpd_pkg;

   localparam int POS_W    = 12;
   localparam int SENSE_W  = 10;
   localparam int SPEED_W  = 8;
   localparam int STATUS_W = 2;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   // internal arithmetic widths
   localparam int ERR_W   = 12;
   localparam int DERIV_W = 13;
   localparam int REM_W   = 15;
   localparam int QUO_W   = 19;
   localparam int PTERM_W = 8;
   localparam int DTERM_W = 14;
   localparam int CORR_W  = 20;

   localparam logic [POS_W-1:0] POS_MAX    = 12'd4000;
   localparam logic [POS_W-1:0] POS_CENTRE = 12'd2000;

   // error/20 as multiply by 3277 and shift by 16, exact for magnitudes up to 2000
   localparam logic [11:0] RECIP_20    = 12'd3277;
   localparam int          RECIP_SHIFT = 16;

   // integral kept as quotient and remainder of division by 10000
   localparam logic signed [REM_W-1:0] INT_DIV     = 15'sd10000;
   localparam logic signed [REM_W-1:0] REM_SAT_HI  = 15'sd3647;
   localparam logic signed [REM_W-1:0] REM_SAT_LO  = -15'sd3648;
   localparam logic signed [QUO_W-1:0] QUO_SAT     = 19'sd214748;
   localparam logic signed [QUO_W-1:0] QUO_ONE     = 19'sd1;

   localparam logic [SPEED_W-1:0] START_SPEED_RST = 8'd100;
   localparam logic [SPEED_W-1:0] SPEED_CAP_RST   = 8'd255;
   localparam logic [SENSE_W-1:0] WHITE_LEVEL_RST = 10'd100;
   localparam logic [SENSE_W-1:0] LINE_LEVEL_RST  = 10'd200;

   typedef enum logic [1:0] {
      CSR_START_SPEED = 2'd0,
      CSR_SPEED_CAP   = 2'd1,
      CSR_WHITE_LEVEL = 2'd2,
      CSR_LINE_LEVEL  = 2'd3
   } csr_idx_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_FOLLOW = 2'd0,
      STAT_CENTRE = 2'd1,
      STAT_BRANCH = 2'd2,
      STAT_HALT   = 2'd3
   } status_type;

   typedef struct packed {
      logic [POS_W-1:0]   position;
      logic [SENSE_W-1:0] sense_far_left;
      logic [SENSE_W-1:0] sense_left;
      logic [SENSE_W-1:0] sense_middle;
      logic [SENSE_W-1:0] sense_right;
      logic [SENSE_W-1:0] sense_far_right;
   } item_type;

   typedef struct packed {
      logic [SPEED_W-1:0] speed_cap;
      logic [SENSE_W-1:0] white_level;
      logic [SENSE_W-1:0] line_level;
      logic               speed_wr;
      logic [SPEED_W-1:0] speed_wdata;
   } cfg_type;

   typedef struct packed {
      logic signed [PTERM_W-1:0] p_term;
      logic signed [QUO_W-1:0]   i_term;
      logic signed [DTERM_W-1:0] d_term;
      logic [SPEED_W-1:0]        lim;
      logic [SPEED_W-1:0]        speed_now;
      status_type                status;
      logic                      stop;
   } terms_type;

endpackage
`default_nettype wire

// File: rtl/line_follow_pid_drive_core.sv
// top level of the pid line follower drive core: csr block, pipeline control, result register
// a word passes the input register, the pid terms register and the result register
// throughput: one word per cycle unless rsp_ready stalls; the state stage updates the
// integral, last error and speed limit per word, so consecutive words see each other's state
// reset (synchronous, active high) empties the pipe, loads the csr defaults,
// sets the speed limit to start_speed and clears integral, last error and halt
`timescale 1ns / 1ps
`default_nettype none
module line_follow_pid_drive_core
   import lfpd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [POS_W-1:0]   req_position,
   input  wire logic [SENSE_W-1:0] req_sense_far_left,
   input  wire logic [SENSE_W-1:0] req_sense_left,
   input  wire logic [SENSE_W-1:0] req_sense_middle,
   input  wire logic [SENSE_W-1:0] req_sense_right,
   input  wire logic [SENSE_W-1:0] req_sense_far_right,

   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [SPEED_W-1:0] rsp_left_drive,
   output      logic [SPEED_W-1:0] rsp_right_drive,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic [SPEED_W-1:0] rsp_speed_now,

   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [CSR_AW-1:0]  paddr,
   input  wire logic [CSR_DW-1:0]  pwdata,
   output      logic [CSR_DW-1:0]  prdata,
   output      logic               pready
);

   logic [SPEED_W-1:0] start_speed_ff, start_speed_in;
   logic [SPEED_W-1:0] speed_cap_ff, speed_cap_in;
   logic [SENSE_W-1:0] white_level_ff, white_level_in;
   logic [SENSE_W-1:0] line_level_ff, line_level_in;

   logic        csr_wr;
   csr_idx_type csr_idx;
   cfg_type     cfg;

   logic     s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic     out_en, s2_en, s1_en;
   item_type item_ff;
   terms_type terms;

   logic [SPEED_W-1:0] left_drive, right_drive, speed_now;
   status_type         status;

   logic [SPEED_W-1:0] rsp_left_drive_ff, rsp_right_drive_ff, rsp_speed_now_ff;
   status_type         rsp_status_ff;

   // configuration registers
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = csr_idx_type'(paddr[3:2]);

   always_comb begin
      start_speed_in = start_speed_ff;
      speed_cap_in   = speed_cap_ff;
      white_level_in = white_level_ff;
      line_level_in  = line_level_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_START_SPEED: start_speed_in = pwdata[SPEED_W-1:0];
            CSR_SPEED_CAP:   speed_cap_in   = pwdata[SPEED_W-1:0];
            CSR_WHITE_LEVEL: white_level_in = pwdata[SENSE_W-1:0];
            CSR_LINE_LEVEL:  line_level_in  = pwdata[SENSE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_speed_ff <= START_SPEED_RST;
         speed_cap_ff   <= SPEED_CAP_RST;
         white_level_ff <= WHITE_LEVEL_RST;
         line_level_ff  <= LINE_LEVEL_RST;
      end else begin
         start_speed_ff <= start_speed_in;
         speed_cap_ff   <= speed_cap_in;
         white_level_ff <= white_level_in;
         line_level_ff  <= line_level_in;
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_START_SPEED: prdata = CSR_DW'(start_speed_ff);
         CSR_SPEED_CAP:   prdata = CSR_DW'(speed_cap_ff);
         CSR_WHITE_LEVEL: prdata = CSR_DW'(white_level_ff);
         CSR_LINE_LEVEL:  prdata = CSR_DW'(line_level_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg.speed_cap   = speed_cap_ff;
   assign cfg.white_level = white_level_ff;
   assign cfg.line_level  = line_level_ff;
   assign cfg.speed_wr    = csr_wr && (csr_idx == CSR_START_SPEED);
   assign cfg.speed_wdata = pwdata[SPEED_W-1:0];

   // each stage moves when it is empty or the stage after it moves
   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign s2_en     = !s2_valid_ff || out_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_en) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_en) begin
         item_ff.position        <= req_position;
         item_ff.sense_far_left  <= req_sense_far_left;
         item_ff.sense_left      <= req_sense_left;
         item_ff.sense_middle    <= req_sense_middle;
         item_ff.sense_right     <= req_sense_right;
         item_ff.sense_far_right <= req_sense_far_right;
      end
   end

   lfpd_loop u_loop (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff),
      .advance    (s2_en),
      .item       (item_ff),
      .cfg        (cfg),
      .terms      (terms)
   );

   lfpd_steer u_steer (
      .terms       (terms),
      .left_drive  (left_drive),
      .right_drive (right_drive),
      .status      (status),
      .speed_now   (speed_now)
   );

   always_ff @(posedge clock) begin
      if (s2_valid_ff && out_en) begin
         rsp_left_drive_ff  <= left_drive;
         rsp_right_drive_ff <= right_drive;
         rsp_status_ff      <= status;
         rsp_speed_now_ff   <= speed_now;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_drive  = rsp_left_drive_ff;
   assign rsp_right_drive = rsp_right_drive_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_speed_now   = rsp_speed_now_ff;

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff))
      else $error("input stalled with a free pipeline stage");

   a_drive_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_left_drive_ff <= rsp_speed_now_ff) &&
                        (rsp_right_drive_ff <= rsp_speed_now_ff)))
      else $error("wheel drive above speed limit");

endmodule
`default_nettype wire

// File: rtl/lfpd_loop.sv
// state stage: error, integral, derivative, speed limit and halt state, registers pid terms
`timescale 1ns / 1ps
`default_nettype none
module lfpd_loop
   import lfpd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      item_valid,
   input  wire logic      advance,
   input  wire item_type  item,
   input  wire cfg_type   cfg,
   output      terms_type terms
);

   logic [SPEED_W-1:0]      speed_ff, speed_in;
   logic signed [QUO_W-1:0] quo_ff, quo_in;
   logic signed [REM_W-1:0] rem_ff, rem_in;
   logic signed [ERR_W-1:0] prior_ff, prior_in;
   logic                    halted_ff, halted_in;
   terms_type               terms_ff, terms_in;

   logic                      go;
   logic [POS_W-1:0]          pos_sat;
   logic signed [ERR_W-1:0]   err;
   logic                      err_neg;
   logic [ERR_W-1:0]          mag_full;
   logic [22:0]               prod;
   logic [6:0]                p_quo;
   logic signed [DERIV_W-1:0] deriv;
   logic signed [REM_W-1:0]   d3, d_adj;
   logic signed [REM_W-1:0]   t, t1;
   logic signed [QUO_W-1:0]   q1;
   logic                      q_pos;
   logic                      w_fl, w_l, w_m, w_r, w_fr;
   logic                      all_white, centre_white, branch;
   logic [SPEED_W-1:0]        speed_up;

   assign go = item_valid && advance;

   always_comb begin
      pos_sat = (item.position > POS_MAX) ? POS_MAX : item.position;
      err     = signed'(pos_sat - POS_CENTRE);

      // proportional term: truncating divide by 20 on the magnitude
      err_neg  = err[ERR_W-1];
      mag_full = err_neg ? (~err + 1'b1) : err;
      prod     = 23'(mag_full[10:0]) * 23'(RECIP_20);
      p_quo    = prod[RECIP_SHIFT+6:RECIP_SHIFT];
      terms_in.p_term = err_neg ? -signed'({1'b0, p_quo}) : signed'({1'b0, p_quo});

      // derivative term: 3*deriv/2 rounded toward zero
      deriv = {err[ERR_W-1], err} - {prior_ff[ERR_W-1], prior_ff};
      d3    = {{2{deriv[DERIV_W-1]}}, deriv} + {deriv[DERIV_W-1], deriv, 1'b0};
      d_adj = d3 + {{(REM_W-1){1'b0}}, d3[REM_W-1]};
      terms_in.d_term = d_adj[REM_W-1:1];

      // integral: add error to remainder, renormalize so remainder sign follows the sum
      t     = rem_ff + {{(REM_W-ERR_W){err[ERR_W-1]}}, err};
      q_pos = !quo_ff[QUO_W-1] && (quo_ff != '0);
      q1    = quo_ff;
      t1    = t;
      if (t >= INT_DIV) begin
         q1 = quo_ff + QUO_ONE;
         t1 = t - INT_DIV;
      end else if (t <= -INT_DIV) begin
         q1 = quo_ff - QUO_ONE;
         t1 = t + INT_DIV;
      end else if (q_pos && t[REM_W-1]) begin
         q1 = quo_ff - QUO_ONE;
         t1 = t + INT_DIV;
      end else if (quo_ff[QUO_W-1] && !t[REM_W-1] && (t != '0)) begin
         q1 = quo_ff + QUO_ONE;
         t1 = t - INT_DIV;
      end
      // 32-bit signed saturation of the running sum
      if (q1 == QUO_SAT && t1 > REM_SAT_HI) begin
         t1 = REM_SAT_HI;
      end
      if (q1 == -QUO_SAT && t1 < REM_SAT_LO) begin
         t1 = REM_SAT_LO;
      end
      terms_in.i_term = q1;

      w_fl = item.sense_far_left  < cfg.white_level;
      w_l  = item.sense_left      < cfg.white_level;
      w_m  = item.sense_middle    < cfg.white_level;
      w_r  = item.sense_right     < cfg.white_level;
      w_fr = item.sense_far_right < cfg.white_level;
      all_white    = w_fl && w_l && w_m && w_r && w_fr;
      centre_white = w_l && w_m && w_r;
      branch       = (item.sense_far_left > cfg.line_level) ||
                     (item.sense_far_right > cfg.line_level);
      speed_up = (speed_ff < cfg.speed_cap) ? speed_ff + 1'b1 : speed_ff;

      speed_in  = speed_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      prior_in  = prior_ff;
      halted_in = halted_ff;
      terms_in.lim    = speed_ff;
      terms_in.status = STAT_FOLLOW;
      terms_in.stop   = 1'b0;

      if (halted_ff) begin
         terms_in.status = STAT_HALT;
         terms_in.stop   = 1'b1;
      end else if (all_white) begin
         terms_in.status = STAT_HALT;
         terms_in.stop   = 1'b1;
         if (go) begin
            halted_in = 1'b1;
         end
      end else if (centre_white) begin
         terms_in.status = STAT_CENTRE;
         if (go) begin
            speed_in = speed_up;
            quo_in   = '0;
            rem_in   = '0;
            prior_in = '0;
         end
      end else if (branch) begin
         terms_in.status = STAT_BRANCH;
         if (go) begin
            quo_in   = '0;
            rem_in   = '0;
            prior_in = '0;
         end
      end else if (go) begin
         quo_in   = q1;
         rem_in   = t1;
         prior_in = err;
      end

      terms_in.speed_now = (!halted_ff && !all_white && centre_white) ? speed_up : speed_ff;

      // start_speed write reloads the limit; write it only while the pipe is empty (not enforced here)
      if (cfg.speed_wr) begin
         speed_in = cfg.speed_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff  <= START_SPEED_RST;
         quo_ff    <= '0;
         rem_ff    <= '0;
         prior_ff  <= '0;
         halted_ff <= 1'b0;
      end else begin
         speed_ff  <= speed_in;
         quo_ff    <= quo_in;
         rem_ff    <= rem_in;
         prior_ff  <= prior_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         terms_ff <= terms_in;
      end
   end

   assign terms = terms_ff;

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt state cleared without reset");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (rem_ff < INT_DIV) && (rem_ff > -INT_DIV))
      else $error("integral remainder out of range");

   a_rem_sign: assert property (@(posedge clock) disable iff (reset)
      ((!quo_ff[QUO_W-1] && (quo_ff != '0)) |-> !rem_ff[REM_W-1]) and
      (quo_ff[QUO_W-1] |-> (rem_ff[REM_W-1] || (rem_ff == '0))))
      else $error("integral remainder sign disagrees with quotient");

endmodule
`default_nettype wire

// File: rtl/lfpd_steer.sv
// output stage logic: sums pid terms, clamps to the speed limit and splits onto the wheels
`timescale 1ns / 1ps
`default_nettype none
module lfpd_steer
   import lfpd_pkg::*;
(
   input  wire terms_type          terms,
   output      logic [SPEED_W-1:0] left_drive,
   output      logic [SPEED_W-1:0] right_drive,
   output      status_type         status,
   output      logic [SPEED_W-1:0] speed_now
);

   logic signed [CORR_W-1:0] corr, corr_c, lim_s, lsum, rdiff;

   always_comb begin
      corr = {{(CORR_W-PTERM_W){terms.p_term[PTERM_W-1]}}, terms.p_term}
           + {{(CORR_W-QUO_W){terms.i_term[QUO_W-1]}}, terms.i_term}
           + {{(CORR_W-DTERM_W){terms.d_term[DTERM_W-1]}}, terms.d_term};
      lim_s = signed'({{(CORR_W-SPEED_W){1'b0}}, terms.lim});
      if (corr > lim_s) begin
         corr_c = lim_s;
      end else if (corr < -lim_s) begin
         corr_c = -lim_s;
      end else begin
         corr_c = corr;
      end
      lsum  = lim_s + corr_c;
      rdiff = lim_s - corr_c;

      if (terms.stop) begin
         left_drive  = '0;
         right_drive = '0;
      end else if (corr_c[CORR_W-1]) begin
         left_drive  = lsum[SPEED_W-1:0];
         right_drive = terms.lim;
      end else begin
         left_drive  = terms.lim;
         right_drive = rdiff[SPEED_W-1:0];
      end
      status    = terms.status;
      speed_now = terms.speed_now;
   end

endmodule
`default_nettype wire
